// ----- sv/rtucrc_pkg.sv -----
// ============================================================================
// rtucrc_pkg - shared types and constants of the RTU frame CRC check unit
// Holds the request and result formats, the internal job format, the
// CRC-16 byte update and the byte position and status codes.
// ============================================================================
package rtucrc_pkg;

    // Reflected CRC-16 used on RTU links.
    localparam logic [15:0] CRC_START = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'hA001;

    // Function byte: top bit flags an exception reply.
    localparam int          EXC_BIT   = 7;

    // Byte positions within a frame; the counter saturates at POS_MAX.
    localparam logic [2:0]  POS_UNIT       = 3'd0;
    localparam logic [2:0]  POS_FUNC       = 3'd1;
    localparam logic [2:0]  POS_EXC        = 3'd2;
    localparam logic [2:0]  POS_FIRST_DATA = 3'd4;
    localparam logic [2:0]  POS_MAX        = 3'd5;

    // Frame status codes.
    localparam logic [1:0]  ST_OK      = 2'd0;
    localparam logic [1:0]  ST_SHORT   = 2'd1;
    localparam logic [1:0]  ST_CRC_BAD = 2'd2;

    // Result kinds.
    localparam logic        KIND_DATA   = 1'b0;
    localparam logic        KIND_STATUS = 1'b1;

    // Job queue between the front and back parts.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    typedef logic [QPTR_W-1:0] t_qptr;
    typedef logic [QPTR_W:0]   t_qcnt;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       end_of_frame;
    } t_in_item;

    typedef struct packed {
        logic        item_kind;
        logic [7:0]  payload_byte;
        logic [1:0]  frame_status;
        logic [7:0]  unit_address;
        logic [6:0]  function_number;
        logic        exception_flag;
        logic [7:0]  exception_number;
        logic [15:0] received_check;
        logic [15:0] computed_check;
        logic        last_of_run;
    } t_out_item;

    // One classified request: an optional data byte and an optional status.
    typedef struct packed {
        logic        has_payload;
        logic        has_status;
        logic [7:0]  payload_byte;
        logic [1:0]  frame_status;
        logic [7:0]  unit_address;
        logic [6:0]  function_number;
        logic        exception_flag;
        logic [7:0]  exception_number;
        logic [15:0] received_check;
        logic [15:0] computed_check;
    } t_job;

    // Byte-wise update of the reflected CRC, eight shift steps unrolled.
    function automatic logic [15:0] crc_feed(logic [15:0] crc, logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ----- sv/rtucrc_in_if.sv -----
// ============================================================================
// rtucrc_in_if - frame byte channel
// Valid/ready channel that carries one frame byte and its end mark.
// ============================================================================
interface rtucrc_in_if;
    logic                 valid;
    logic                 ready;
    rtucrc_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/rtucrc_out_if.sv -----
// ============================================================================
// rtucrc_out_if - result channel
// Valid/ready channel that carries data bytes and end-of-frame status.
// ============================================================================
interface rtucrc_out_if;
    logic                  valid;
    logic                  ready;
    rtucrc_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/rtucrc_front.sv -----
// ============================================================================
// rtucrc_front - frame tracking and classification
// Accepts frame bytes, runs the delay pair and the CRC, captures the header
// bytes and turns each request into a job for the back part.
// ============================================================================
module rtucrc_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    rtucrc_in_if.sink         i_in,
    input  logic              i_q_full,
    output logic              o_push,
    output rtucrc_pkg::t_job  o_job
);

    logic [15:0] r_crc,    n_crc;
    logic [7:0]  r_older,  n_older;
    logic [7:0]  r_newer,  n_newer;
    logic [2:0]  r_pos,    n_pos;
    logic [7:0]  r_unit,   n_unit;
    logic [7:0]  r_func,   n_func;
    logic [7:0]  r_exc,    n_exc;

    logic        w_acc;
    logic        w_eof;
    logic [7:0]  w_byte;
    logic [15:0] w_rx;

    assign i_in.ready = !i_q_full;
    assign w_acc      = i_in.valid && i_in.ready;
    assign w_eof      = i_in.data.end_of_frame;
    assign w_byte     = i_in.data.frame_byte;

    // Next state of the frame tracker and the job that this request makes.
    always_comb begin
        n_crc   = r_crc;
        n_older = r_older;
        n_newer = r_newer;
        n_pos   = r_pos;
        n_unit  = r_unit;
        n_func  = r_func;
        n_exc   = r_exc;
        o_push  = 1'b0;
        o_job   = '0;
        w_rx    = {w_byte, r_newer};

        if (w_acc) begin
            // The byte leaving the delay pair goes into the CRC.
            if (r_pos >= rtucrc_pkg::POS_EXC) begin
                n_crc = rtucrc_pkg::crc_feed(r_crc, r_older);
            end
            n_older = r_newer;
            n_newer = w_byte;

            if (r_pos == rtucrc_pkg::POS_UNIT) begin
                n_unit = w_byte;
            end
            if (r_pos == rtucrc_pkg::POS_FUNC) begin
                n_func = w_byte;
            end
            if (r_pos == rtucrc_pkg::POS_EXC) begin
                n_exc = w_byte;
            end
            if (r_pos < rtucrc_pkg::POS_MAX) begin
                n_pos = r_pos + 3'd1;
            end

            // Data bytes leave two bytes late, never for exception replies.
            o_job.has_payload  = (r_pos >= rtucrc_pkg::POS_FIRST_DATA) &&
                                 !r_func[rtucrc_pkg::EXC_BIT];
            o_job.payload_byte = r_older;

            // End of frame: build the status from the updated state.
            o_job.has_status       = w_eof;
            o_job.unit_address     = n_unit;
            o_job.function_number  = n_func[6:0];
            o_job.exception_flag   = n_func[rtucrc_pkg::EXC_BIT];
            o_job.exception_number = n_func[rtucrc_pkg::EXC_BIT] ? n_exc : 8'h00;
            o_job.received_check   = w_rx;
            o_job.computed_check   = n_crc;
            if (r_pos < rtucrc_pkg::POS_FIRST_DATA) begin
                o_job.frame_status = rtucrc_pkg::ST_SHORT;
            end else if (w_rx != n_crc) begin
                o_job.frame_status = rtucrc_pkg::ST_CRC_BAD;
            end else begin
                o_job.frame_status = rtucrc_pkg::ST_OK;
            end

            o_push = o_job.has_payload || w_eof;

            // A finished frame puts the tracker back to its start state.
            if (w_eof) begin
                n_crc   = rtucrc_pkg::CRC_START;
                n_older = 8'h00;
                n_newer = 8'h00;
                n_pos   = rtucrc_pkg::POS_UNIT;
                n_unit  = 8'h00;
                n_func  = 8'h00;
                n_exc   = 8'h00;
            end
        end
    end

    // Tracker registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc   <= rtucrc_pkg::CRC_START;
            r_older <= 8'h00;
            r_newer <= 8'h00;
            r_pos   <= rtucrc_pkg::POS_UNIT;
            r_unit  <= 8'h00;
            r_func  <= 8'h00;
            r_exc   <= 8'h00;
        end else begin
            r_crc   <= n_crc;
            r_older <= n_older;
            r_newer <= n_newer;
            r_pos   <= n_pos;
            r_unit  <= n_unit;
            r_func  <= n_func;
            r_exc   <= n_exc;
        end
    end

    // A frame end always returns the position counter to the start.
    a_eof_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_eof) |=> (r_pos == rtucrc_pkg::POS_UNIT))
        else $error("position counter not restarted after frame end");

    // The position counter saturates and never passes its top value.
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= rtucrc_pkg::POS_MAX)
        else $error("position counter out of range");

endmodule

// ----- sv/rtucrc_queue.sv -----
// ============================================================================
// rtucrc_queue - job queue
// Short first-in first-out buffer of jobs between the front and back parts.
// ============================================================================
module rtucrc_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  rtucrc_pkg::t_job  i_push_job,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_head_valid,
    output rtucrc_pkg::t_job  o_head
);

    rtucrc_pkg::t_job  r_mem [rtucrc_pkg::QDEPTH];
    rtucrc_pkg::t_qptr r_wr_ptr, n_wr_ptr;
    rtucrc_pkg::t_qptr r_rd_ptr, n_rd_ptr;
    rtucrc_pkg::t_qcnt r_count,  n_count;

    assign o_full       = (r_count == rtucrc_pkg::t_qcnt'(rtucrc_pkg::QDEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];

    // Pointer and fill count update.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Job storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_job;
        end
    end

    // The front part must hold off while the queue is full.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("job pushed into a full queue");

    // The back part only takes jobs that are there.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_head_valid)
        else $error("job popped from an empty queue");

endmodule

// ----- sv/rtucrc_back.sv -----
// ============================================================================
// rtucrc_back - result issue
// Expands each job into its data and status results and drives them
// through the output register.
// ============================================================================
module rtucrc_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_head_valid,
    input  rtucrc_pkg::t_job  i_head,
    output logic              o_pop,
    rtucrc_out_if.source      o_out
);

    logic                  r_out_valid, n_out_valid;
    rtucrc_pkg::t_out_item r_out_data,  n_out_data;
    logic                  r_done_pay,  n_done_pay;
    logic                  w_load;

    assign w_load      = !r_out_valid || o_out.ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;

    // Pick the next result of the head job when the output register frees.
    always_comb begin
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_done_pay  = r_done_pay;
        o_pop       = 1'b0;

        if (w_load) begin
            n_out_valid = 1'b0;
            if (i_head_valid) begin
                n_out_valid = 1'b1;
                n_out_data  = '0;
                if (i_head.has_payload && !r_done_pay) begin
                    // Data byte first; a status in the same job follows.
                    n_out_data.item_kind    = rtucrc_pkg::KIND_DATA;
                    n_out_data.payload_byte = i_head.payload_byte;
                    n_out_data.last_of_run  = !i_head.has_status;
                    if (i_head.has_status) begin
                        n_done_pay = 1'b1;
                    end else begin
                        o_pop = 1'b1;
                    end
                end else begin
                    n_out_data.item_kind        = rtucrc_pkg::KIND_STATUS;
                    n_out_data.frame_status     = i_head.frame_status;
                    n_out_data.unit_address     = i_head.unit_address;
                    n_out_data.function_number  = i_head.function_number;
                    n_out_data.exception_flag   = i_head.exception_flag;
                    n_out_data.exception_number = i_head.exception_number;
                    n_out_data.received_check   = i_head.received_check;
                    n_out_data.computed_check   = i_head.computed_check;
                    n_out_data.last_of_run      = 1'b1;
                    n_done_pay                  = 1'b0;
                    o_pop                       = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_done_pay  <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            r_done_pay  <= n_done_pay;
        end
    end

    // Output payload register.
    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

    // A half-issued job is still at the head and carries both results.
    a_split_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done_pay |-> (i_head_valid && i_head.has_payload && i_head.has_status))
        else $error("half-issued job lost from the queue head");

endmodule

// ----- sv/rtu_frame_receiver_crc_check_unit.sv -----
// ============================================================================
// rtu_frame_receiver_crc_check_unit - RTU frame receiver with CRC-16 check
// Strips the header and the check bytes of RTU frames and reports a status.
// ============================================================================
// Usage:
// Frame bytes enter on i_in, one request per byte, with end_of_frame set on
// the last byte. Results leave on o_out: data bytes from frame index 2 up to
// length minus 3 (none for exception replies), then one status request per
// frame with the header fields, both check values and ok, too short or CRC
// mismatch. On a CRC mismatch the data already sent must be discarded.
// A result passes through the job queue and then the output register before
// it can be taken; the status that follows a data byte on the same request
// is issued once that byte has been taken.
// Throughput: one byte per cycle while the job queue is not full. The single
// CRC byte update sits in the front part; the output register issues one
// result per cycle while o_out is ready, so the data byte and the status
// of a final byte leave in turn. A four-entry job queue lets the front
// keep accepting while o_out stalls; i_in.ready drops only when it is full.
// Reset (synchronous, active low) empties the queue and the output register
// and returns the CRC, delay pair and header capture to their start values.
// ============================================================================
module rtu_frame_receiver_crc_check_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rtucrc_in_if.sink     i_in,
    rtucrc_out_if.source  o_out
);

    logic              w_push;
    rtucrc_pkg::t_job  w_push_job;
    logic              w_pop;
    logic              w_full;
    logic              w_head_valid;
    rtucrc_pkg::t_job  w_head;

    // Front part: frame tracking and CRC.
    rtucrc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (w_full),
        .o_push   (w_push),
        .o_job    (w_push_job)
    );

    // Job queue.
    rtucrc_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_push_job   (w_push_job),
        .i_pop        (w_pop),
        .o_full       (w_full),
        .o_head_valid (w_head_valid),
        .o_head       (w_head)
    );

    // Back part: result issue.
    rtucrc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (w_head_valid),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .o_out        (o_out)
    );

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ============================================================================
// testbench - RTU frame receiver with CRC-16 check
// Sends RTU frames byte by byte: a few hand-picked frames first, then random
// frames that mostly carry a correct check, with bad checks, short frames
// and loose byte runs mixed in. A scoreboard tracks the CRC, the delay pair
// and the header capture per accepted byte, and compares every result field
// by field. The run passes through phases of sender idling and receiver
// stalling.
// ============================================================================
module testbench;

    localparam int REPORT_LIMIT = 10;

    typedef logic [7:0] t_octet_q[$];

    // Scoreboard: follows the frame state for each accepted request and
    // holds the results that are still on their way.
    class t_frame_scoreboard;
        int                    failures;
        int                    results_seen;
        rtucrc_pkg::t_out_item awaited[$];
        logic [15:0]           crc;
        logic [7:0]            older;
        logic [7:0]            newer;
        logic [2:0]            pos;
        logic [7:0]            unit;
        logic [7:0]            func;
        logic [7:0]            exc_code;

        function new();
            failures     = 0;
            results_seen = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            crc      = rtucrc_pkg::CRC_START;
            older    = 8'h00;
            newer    = 8'h00;
            pos      = rtucrc_pkg::POS_UNIT;
            unit     = 8'h00;
            func     = 8'h00;
            exc_code = 8'h00;
        endfunction

        // Bit-serial form of the reflected CRC-16, low bit of the byte first.
        static function logic [15:0] crc16_byte(logic [15:0] start, logic [7:0] value);
            logic [15:0] c;
            logic        fb;
            c = start;
            for (int k = 0; k < 8; k++) begin
                fb = c[0] ^ value[k];
                c  = {1'b0, c[15:1]} ^ (fb ? rtucrc_pkg::CRC_POLY : 16'h0000);
            end
            return c;
        endfunction

        function int outstanding();
            return awaited.size();
        endfunction

        // Work out the results that one accepted frame byte causes.
        function void take_frame_byte(rtucrc_pkg::t_in_item req);
            rtucrc_pkg::t_out_item r;
            logic [7:0]            leaving;
            logic [2:0]            idx;
            idx     = pos;
            leaving = older;
            if (idx >= rtucrc_pkg::POS_EXC) begin
                crc = crc16_byte(crc, leaving);
            end
            older = newer;
            newer = req.frame_byte;
            case (idx)
                rtucrc_pkg::POS_UNIT: unit     = req.frame_byte;
                rtucrc_pkg::POS_FUNC: func     = req.frame_byte;
                rtucrc_pkg::POS_EXC:  exc_code = req.frame_byte;
                default: ;
            endcase

            // The byte that leaves the delay pair is data, unless this is
            // an exception reply.
            if (idx >= rtucrc_pkg::POS_FIRST_DATA && !func[rtucrc_pkg::EXC_BIT]) begin
                r              = '0;
                r.item_kind    = rtucrc_pkg::KIND_DATA;
                r.payload_byte = leaving;
                r.last_of_run  = !req.end_of_frame;
                awaited.insert(awaited.size(), r);
            end
            if (idx < rtucrc_pkg::POS_MAX) begin
                pos = idx + 3'd1;
            end

            // Frame end: status with header fields and both check values.
            if (req.end_of_frame) begin
                r                  = '0;
                r.item_kind        = rtucrc_pkg::KIND_STATUS;
                r.unit_address     = unit;
                r.function_number  = func[6:0];
                r.exception_flag   = func[rtucrc_pkg::EXC_BIT];
                r.exception_number = func[rtucrc_pkg::EXC_BIT] ? exc_code : 8'h00;
                r.received_check   = {newer, older};
                r.computed_check   = crc;
                r.last_of_run      = 1'b1;
                if (idx < rtucrc_pkg::POS_FIRST_DATA) begin
                    r.frame_status = rtucrc_pkg::ST_SHORT;
                end else if ({newer, older} != crc) begin
                    r.frame_status = rtucrc_pkg::ST_CRC_BAD;
                end else begin
                    r.frame_status = rtucrc_pkg::ST_OK;
                end
                awaited.insert(awaited.size(), r);
                clear_frame();
            end
        endfunction

        function void check_field(string name, logic [15:0] want, logic [15:0] got);
            if (want !== got) begin
                failures++;
                if (failures <= REPORT_LIMIT) begin
                    $display("result %0d: %s expected %h, got %h",
                             results_seen, name, want, got);
                end
            end
        endfunction

        // Compare one accepted result with the oldest expectation.
        function void compare_result(rtucrc_pkg::t_out_item got);
            rtucrc_pkg::t_out_item want;
            results_seen++;
            if (awaited.size() == 0) begin
                failures++;
                if (failures <= REPORT_LIMIT) begin
                    $display("result %0d arrived with nothing outstanding: %h",
                             results_seen, got);
                end
                return;
            end
            want = awaited.pop_front();
            check_field("item_kind",        want.item_kind,        got.item_kind);
            check_field("payload_byte",     want.payload_byte,     got.payload_byte);
            check_field("frame_status",     want.frame_status,     got.frame_status);
            check_field("unit_address",     want.unit_address,     got.unit_address);
            check_field("function_number",  want.function_number,  got.function_number);
            check_field("exception_flag",   want.exception_flag,   got.exception_flag);
            check_field("exception_number", want.exception_number, got.exception_number);
            check_field("received_check",   want.received_check,   got.received_check);
            check_field("computed_check",   want.computed_check,   got.computed_check);
            check_field("last_of_run",      want.last_of_run,      got.last_of_run);
        endfunction

        // Anything still outstanding at the end never arrived.
        function void account_leftovers();
            if (awaited.size() != 0) begin
                failures += awaited.size();
                if (failures <= REPORT_LIMIT + awaited.size()) begin
                    $display("%0d expected results never arrived", awaited.size());
                end
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    rtucrc_in_if  in_ch();
    rtucrc_out_if out_ch();

    t_frame_scoreboard board = new();

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int items_sent     = 0;

    rtu_frame_receiver_crc_check_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #4 i_clk = ~i_clk;

    // Receiver side: random stalls at the set rate.
    always @(negedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Result monitor.
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            board.compare_result(out_ch.data);
        end
    end

    // Offer one frame byte, idling first at the set rate, and hold it until
    // the request is taken.
    task automatic send_item(input logic [7:0] value, input logic last);
        rtucrc_pkg::t_in_item req;
        req.frame_byte   = value;
        req.end_of_frame = last;
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= req;
        do @(posedge i_clk); while (!in_ch.ready);
        board.take_frame_byte(req);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_frame(input t_octet_q f);
        foreach (f[k]) begin
            send_item(f[k], k == f.size() - 1);
        end
    endtask

    // Append the check bytes, low byte first, optionally damaged.
    function automatic t_octet_q seal_frame(t_octet_q body, bit corrupt);
        logic [15:0] c;
        t_octet_q    f;
        c = rtucrc_pkg::CRC_START;
        foreach (body[k]) begin
            c = t_frame_scoreboard::crc16_byte(c, body[k]);
        end
        if (corrupt) begin
            c ^= 16'($urandom_range(1, 65535));
        end
        f = body;
        f.insert(f.size(), c[7:0]);
        f.insert(f.size(), c[15:8]);
        return f;
    endfunction

    // Mostly well-formed frames; some with a bad check, some too short and
    // some loose byte runs.
    task automatic send_random_frame();
        t_octet_q   body;
        logic [7:0] fcode;
        int         roll;
        int         n;
        roll = $urandom_range(99);
        if (roll < 85) begin
            fcode = 8'($urandom_range(127));
            if ($urandom_range(99) < 15) begin
                fcode[rtucrc_pkg::EXC_BIT] = 1'b1;
            end
            body.insert(body.size(), 8'($urandom_range(255)));
            body.insert(body.size(), fcode);
            if (fcode[rtucrc_pkg::EXC_BIT]) begin
                n = ($urandom_range(3) == 0) ? $urandom_range(0, 4) : 1;
            end else if ($urandom_range(19) == 0) begin
                n = $urandom_range(9, 20);
            end else begin
                n = $urandom_range(0, 6);
            end
            repeat (n) body.insert(body.size(), 8'($urandom_range(255)));
            send_frame(seal_frame(body, roll >= 70));
        end else begin
            n = (roll < 95) ? $urandom_range(1, 4) : $urandom_range(1, 12);
            repeat (n) body.insert(body.size(), 8'($urandom_range(255)));
            send_frame(body);
        end
    endtask

    // Hold off the sender until every outstanding result has come back.
    task automatic wait_for_drain();
        in_ch.valid <= 1'b0;
        while (board.outstanding() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Main sequence.
    initial begin : stimulus
        t_octet_q f;
        int       phase_end;
        i_rst_n      = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        out_ch.ready = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Single byte frame, all ones.
        f = {8'hFF};
        send_frame(f);
        // Too short exception reply.
        f = {8'h11, 8'h83, 8'h05, 8'h00};
        send_frame(f);
        // Shortest frame that carries one data byte.
        f = {8'h01, 8'h03, 8'hA5};
        send_frame(seal_frame(f, 1'b0));
        // Exception reply with a correct check.
        f = {8'hFF, 8'h83, 8'h02};
        send_frame(seal_frame(f, 1'b0));
        // CRC mismatch.
        f = {8'h00, 8'h7F, 8'h00};
        send_frame(seal_frame(f, 1'b1));
        // Longer frame: position counter saturates, data extremes.
        f = {8'h55, 8'h10, 8'h00, 8'hFF};
        send_frame(seal_frame(f, 1'b0));

        // Random frames through the idling phases.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
                default: begin send_idle_pct = 27; recv_stall_pct = 27; end
            endcase
            phase_end = 26 + 165 * (phase + 1);
            while (items_sent < phase_end) begin
                send_random_frame();
            end
            wait_for_drain();
        end

        repeat (10) @(negedge i_clk);
        board.account_leftovers();
        if (board.failures == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #1_000_000;
        $display("testbench NOT OK");
        $finish;
    end

endmodule
